// ===== hdl/abl_wd_pkg.sv =====
// Package: widths, register indexes, reset values and item types of the wall dissipation block.
package abl_wd_pkg;

	localparam int IN_W       = 32;
	localparam int CFG_W      = 18;
	localparam int OUT_W      = 40;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CMU   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KAPPA = 8'd1;

	localparam logic [CFG_W-1:0] CMU_RESET   = 18'd35895;
	localparam logic [CFG_W-1:0] KAPPA_RESET = 18'd26870;

	localparam int ROOT_W = 24;            // sqrt(k << 16)
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int UT_W   = 26;            // friction velocity
	localparam int YZ_W   = IN_W + 1;
	localparam int DEN_W  = CFG_W + YZ_W;  // kappa*(y+z0), Q.32
	localparam int NUM_W  = UT_W + 32;     // ut << 32
	localparam int DUDY_W = 42;            // holds the cap 2^41
	localparam int CKH_W  = 34;
	localparam int CK_W   = 36;
	localparam int NG_W   = 48;
	localparam int MA_W   = 48;
	localparam int MB_W   = DUDY_W;
	localparam int PROD_W = MA_W + MB_W;
	localparam int DIFF_W = DUDY_W + 1;

	localparam logic [DUDY_W-1:0] CAP = {1'b1, 41'd0};
	localparam logic signed [DIFF_W-1:0] OUT_MAX = 43'sd549755813887;
	localparam logic signed [DIFF_W-1:0] OUT_MIN = -43'sd549755813888;

	typedef struct packed {
		logic [IN_W-1:0] cell_tke;
		logic [IN_W-1:0] wall_distance;
		logic [IN_W-1:0] roughness_length;
		logic [IN_W-1:0] laminar_visc;
		logic [IN_W-1:0] eddy_visc;
		logic [IN_W-1:0] shear_grad;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] dissipation;
		logic signed [OUT_W-1:0] production;
		logic                    denom_zero;
	} result_t;

endpackage

// ===== hdl/abl_wd_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a sideband carried alongside.
module abl_wd_isqrt #(
	parameter int SW = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [abl_wd_pkg::RAD_W-1:0]  rad,
	input  logic [SW-1:0]                  in_side,
	output logic                           out_valid,
	output logic [abl_wd_pkg::ROOT_W-1:0] root,
	output logic [SW-1:0]                  out_side
);
	localparam int N    = abl_wd_pkg::ROOT_W;
	localparam int RM_W = N + 2;

	logic                           v_s    [0:N];
	logic [abl_wd_pkg::RAD_W-1:0]  rad_s  [0:N];
	logic [RM_W-1:0]                rem_s  [0:N];
	logic [N-1:0]                   root_s [0:N];
	logic [SW-1:0]                  side_s [0:N];

	assign v_s[0]    = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < N; j++) begin : g_st
		logic [RM_W-1:0] rsh;
		logic [RM_W-1:0] trial;
		logic            ge;

		assign rsh   = {rem_s[j][RM_W-3:0], rad_s[j][abl_wd_pkg::RAD_W-1 -: 2]};
		assign trial = {root_s[j], 2'b01};
		assign ge    = rsh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j+1] <= 1'b0;
			else v_s[j+1] <= v_s[j];
		end

		always_ff @(posedge clk) begin
			rad_s[j+1]  <= rad_s[j] << 2;
			rem_s[j+1]  <= ge ? rsh - trial : rsh;
			root_s[j+1] <= {root_s[j][N-2:0], ge};
			side_s[j+1] <= side_s[j];
		end
	end

	assign out_valid = v_s[N];
	assign root      = root_s[N];
	assign out_side  = side_s[N];
endmodule

// ===== hdl/abl_wd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband carried alongside.
module abl_wd_div #(
	parameter int SW = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [abl_wd_pkg::NUM_W-1:0] num,
	input  logic [abl_wd_pkg::DEN_W-1:0] den,
	input  logic [SW-1:0]                 in_side,
	output logic                          out_valid,
	output logic [abl_wd_pkg::NUM_W-1:0] quo,
	output logic [SW-1:0]                 out_side
);
	localparam int N  = abl_wd_pkg::NUM_W;
	localparam int DW = abl_wd_pkg::DEN_W;

	logic            v_s    [0:N];
	logic [N-1:0]    num_s  [0:N];
	logic [DW-1:0]   den_s  [0:N];
	logic [DW-1:0]   rem_s  [0:N];
	logic [N-1:0]    quo_s  [0:N];
	logic [SW-1:0]   side_s [0:N];

	assign v_s[0]    = in_valid;
	assign num_s[0]  = num;
	assign den_s[0]  = den;
	assign rem_s[0]  = '0;
	assign quo_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < N; j++) begin : g_st
		logic [DW:0] rs;
		logic [DW:0] diff;
		logic        ge;

		assign rs   = {rem_s[j], num_s[j][N-1]};
		assign diff = rs - {1'b0, den_s[j]};
		assign ge   = rs >= {1'b0, den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j+1] <= 1'b0;
			else v_s[j+1] <= v_s[j];
		end

		always_ff @(posedge clk) begin
			num_s[j+1]  <= num_s[j] << 1;
			den_s[j+1]  <= den_s[j];
			rem_s[j+1]  <= ge ? diff[DW-1:0] : rs[DW-1:0];
			quo_s[j+1]  <= {quo_s[j][N-2:0], ge};
			side_s[j+1] <= side_s[j];
		end
	end

	assign out_valid = v_s[N];
	assign quo       = quo_s[N];
	assign out_side  = side_s[N];
endmodule

// ===== hdl/abl_wd_satmul.sv =====
// Three-stage saturating multiply min((a*b)>>16, 2^41) over several lanes, split in partial products.
module abl_wd_satmul #(
	parameter int LANES = 1,
	parameter int SW    = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [abl_wd_pkg::MA_W-1:0]   a   [LANES],
	input  logic [abl_wd_pkg::MB_W-1:0]   b   [LANES],
	input  logic [SW-1:0]                  in_side,
	output logic                           out_valid,
	output logic [abl_wd_pkg::DUDY_W-1:0] res [LANES],
	output logic [SW-1:0]                  out_side
);
	localparam int AH = abl_wd_pkg::MA_W / 2;
	localparam int BH = abl_wd_pkg::MB_W / 2;
	localparam int PW = abl_wd_pkg::PROD_W;
	localparam int SH = PW - 16;

	logic v_s1, v_s2, v_s3;
	logic [SW-1:0] side_s1, side_s2, side_s3;
	logic [AH+BH-1:0] pp0_s1 [LANES];
	logic [AH+BH-1:0] pp1_s1 [LANES];
	logic [AH+BH-1:0] pp2_s1 [LANES];
	logic [AH+BH-1:0] pp3_s1 [LANES];
	logic [PW-1:0]    p_s2   [LANES];
	logic [abl_wd_pkg::DUDY_W-1:0] r_s3 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= in_side;
		side_s2 <= side_s1;
		side_s3 <= side_s2;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [AH-1:0] al, ah;
		logic [BH-1:0] bl, bh;
		logic [SH-1:0] sh;

		assign al = a[l][AH-1:0];
		assign ah = a[l][2*AH-1:AH];
		assign bl = b[l][BH-1:0];
		assign bh = b[l][2*BH-1:BH];
		assign sh = p_s2[l][PW-1:16];

		always_ff @(posedge clk) begin
			pp0_s1[l] <= (AH+BH)'(al) * (AH+BH)'(bl);
			pp1_s1[l] <= (AH+BH)'(al) * (AH+BH)'(bh);
			pp2_s1[l] <= (AH+BH)'(ah) * (AH+BH)'(bl);
			pp3_s1[l] <= (AH+BH)'(ah) * (AH+BH)'(bh);
			p_s2[l]   <= PW'(pp0_s1[l]) + (PW'(pp1_s1[l]) << BH)
				+ (PW'(pp2_s1[l]) << AH) + (PW'(pp3_s1[l]) << (AH + BH));
			r_s3[l]   <= (sh > SH'(abl_wd_pkg::CAP)) ? abl_wd_pkg::CAP
				: sh[abl_wd_pkg::DUDY_W-1:0];
		end

		assign res[l] = r_s3[l];
	end

	assign out_valid = v_s3;
	assign out_side  = side_s3;
endmodule

// ===== hdl/abl_wall_dissipation_production.sv =====
// Throughput: one item per cycle; busy stays low, since every stage moves each cycle.
// The pipeline holds the 24-stage square root and the 58-stage divider, one bit per stage.
// The receiver cannot stall; each result is shown for exactly one cycle with done.
// Reset (arst_n low) empties the pipeline and restores Cmu^0.25 = 35895 and kappa = 26870.
module abl_wall_dissipation_production (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  abl_wd_pkg::item_t                   item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [abl_wd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [abl_wd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                done,
	output abl_wd_pkg::result_t                 result
);
	localparam int CFG_W  = abl_wd_pkg::CFG_W;
	localparam int IN_W   = abl_wd_pkg::IN_W;
	localparam int DEN_W  = abl_wd_pkg::DEN_W;
	localparam int CK_W   = abl_wd_pkg::CK_W;
	localparam int CKH_W  = abl_wd_pkg::CKH_W;
	localparam int NG_W   = abl_wd_pkg::NG_W;
	localparam int DUDY_W = abl_wd_pkg::DUDY_W;
	localparam int MA_W   = abl_wd_pkg::MA_W;
	localparam int ROOT_W = abl_wd_pkg::ROOT_W;
	localparam int UT_W   = abl_wd_pkg::UT_W;
	localparam int NUM_W  = abl_wd_pkg::NUM_W;
	localparam int OUT_W  = abl_wd_pkg::OUT_W;
	localparam int DIFF_W = abl_wd_pkg::DIFF_W;
	localparam int SQ_SW  = DEN_W + CK_W + NG_W + IN_W;
	localparam int DV_SW  = CK_W + NG_W + IN_W + 1;

	logic [CFG_W-1:0] cmu_q, kappa_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmu_q   <= abl_wd_pkg::CMU_RESET;
			kappa_q <= abl_wd_pkg::KAPPA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				abl_wd_pkg::REG_CMU:   cmu_q   <= cfg_data[CFG_W-1:0];
				abl_wd_pkg::REG_KAPPA: kappa_q <= cfg_data[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: y+z0, C*k and nut*g
	logic                  v_s1;
	logic [IN_W-1:0]       k_s1, nu_s1;
	logic [IN_W:0]         yz_s1;
	logic [CKH_W-1:0]      ckh_s1;
	logic [NG_W-1:0]       ng_s1;
	logic [CFG_W+IN_W-1:0] ck_full;
	logic [2*IN_W-1:0]     ng_full;

	assign ck_full = (CFG_W+IN_W)'(cmu_q) * (CFG_W+IN_W)'(item.cell_tke);
	assign ng_full = (2*IN_W)'(item.eddy_visc) * (2*IN_W)'(item.shear_grad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		k_s1   <= item.cell_tke;
		nu_s1  <= item.laminar_visc;
		yz_s1  <= (IN_W+1)'(item.wall_distance) + (IN_W+1)'(item.roughness_length);
		ckh_s1 <= ck_full[CFG_W+IN_W-1:16];
		ng_s1  <= ng_full[2*IN_W-1:16];
	end

	// stage 2: denominator and C^2*k
	logic                   v_s2;
	logic [IN_W-1:0]        k_s2, nu_s2;
	logic [DEN_W-1:0]       den_s2;
	logic [CK_W-1:0]        ck_s2;
	logic [NG_W-1:0]        ng_s2;
	logic [CFG_W+CKH_W-1:0] ck2_full;

	assign ck2_full = (CFG_W+CKH_W)'(cmu_q) * (CFG_W+CKH_W)'(ckh_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		k_s2   <= k_s1;
		nu_s2  <= nu_s1;
		den_s2 <= DEN_W'(kappa_q) * DEN_W'(yz_s1);
		ck_s2  <= ck2_full[CFG_W+CKH_W-1:16];
		ng_s2  <= ng_s1;
	end

	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	logic [SQ_SW-1:0]  sq_side;

	abl_wd_isqrt #(.SW(SQ_SW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.rad      ({k_s2, 16'd0}),
		.in_side  ({den_s2, ck_s2, ng_s2, nu_s2}),
		.out_valid(sq_valid),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// stage 3: u_tau and zero-denominator flag
	logic                    v_s3;
	logic [UT_W-1:0]         ut_s3;
	logic [DEN_W-1:0]        den_s3;
	logic [CK_W-1:0]         ck_s3;
	logic [NG_W-1:0]         ng_s3;
	logic [IN_W-1:0]         nu_s3;
	logic                    dz_s3;
	logic [CFG_W+ROOT_W-1:0] ut_full;
	logic [DEN_W-1:0]        sq_den;

	assign ut_full = (CFG_W+ROOT_W)'(cmu_q) * (CFG_W+ROOT_W)'(sq_root);
	assign sq_den  = sq_side[SQ_SW-1 -: DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= sq_valid;
	end

	always_ff @(posedge clk) begin
		ut_s3  <= ut_full[CFG_W+ROOT_W-1:16];
		den_s3 <= sq_den;
		{ck_s3, ng_s3, nu_s3} <= sq_side[CK_W+NG_W+IN_W-1:0];
		dz_s3  <= sq_den == '0;
	end

	logic             dv_valid;
	logic [NUM_W-1:0] dv_quo;
	logic [DV_SW-1:0] dv_side;

	abl_wd_div #(.SW(DV_SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.num      ({ut_s3, 32'd0}),
		.den      (den_s3),
		.in_side  ({ck_s3, ng_s3, nu_s3, dz_s3}),
		.out_valid(dv_valid),
		.quo      (dv_quo),
		.out_side (dv_side)
	);

	// stage 4: cap dU/dy
	logic              v_s4;
	logic [DUDY_W-1:0] dudy_s4;
	logic [CK_W-1:0]   ck_s4;
	logic [NG_W-1:0]   ng_s4;
	logic [IN_W-1:0]   nu_s4;
	logic              dz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= dv_valid;
	end

	always_ff @(posedge clk) begin
		dudy_s4 <= (dv_quo > NUM_W'(abl_wd_pkg::CAP)) ? abl_wd_pkg::CAP
			: dv_quo[DUDY_W-1:0];
		{ck_s4, ng_s4, nu_s4, dz_s4} <= dv_side;
	end

	// nu*dUdy, C^2k*dUdy and nut*g*dUdy
	logic [MA_W-1:0]   m1_a [3];
	logic [DUDY_W-1:0] m1_b [3];
	logic [DUDY_W-1:0] m1_r [3];
	logic              m1_valid;
	logic [DUDY_W:0]   m1_side;

	assign m1_a[0] = MA_W'(nu_s4);
	assign m1_a[1] = MA_W'(ck_s4);
	assign m1_a[2] = MA_W'(ng_s4);
	assign m1_b[0] = dudy_s4;
	assign m1_b[1] = dudy_s4;
	assign m1_b[2] = dudy_s4;

	abl_wd_satmul #(.LANES(3), .SW(DUDY_W + 1)) u_mul1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.a        (m1_a),
		.b        (m1_b),
		.in_side  ({dudy_s4, dz_s4}),
		.out_valid(m1_valid),
		.res      (m1_r),
		.out_side (m1_side)
	);

	// viscous term nu*dUdy^2
	logic [MA_W-1:0]     m2_a [1];
	logic [DUDY_W-1:0]   m2_b [1];
	logic [DUDY_W-1:0]   m2_r [1];
	logic                m2_valid;
	logic [2*DUDY_W:0]   m2_side;

	assign m2_a[0] = MA_W'(m1_r[0]);
	assign m2_b[0] = m1_side[DUDY_W:1];

	abl_wd_satmul #(.LANES(1), .SW(2*DUDY_W + 1)) u_mul2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (m1_valid),
		.a        (m2_a),
		.b        (m2_b),
		.in_side  ({m1_r[1], m1_r[2], m1_side[0]}),
		.out_valid(m2_valid),
		.res      (m2_r),
		.out_side (m2_side)
	);

	// output stage: subtract and clamp, or zero both results on a zero denominator
	logic signed [DIFF_W-1:0] dd, dp;
	logic [OUT_W-1:0]         dis_c, prod_c;
	logic                     v_s5;
	abl_wd_pkg::result_t      res_s5;

	assign dd = $signed({1'b0, m2_side[2*DUDY_W -: DUDY_W]}) - $signed({1'b0, m2_r[0]});
	assign dp = $signed({1'b0, m2_side[DUDY_W:1]}) - $signed({1'b0, m2_r[0]});

	always_comb begin
		if (dd > abl_wd_pkg::OUT_MAX) dis_c = abl_wd_pkg::OUT_MAX[OUT_W-1:0];
		else if (dd < abl_wd_pkg::OUT_MIN) dis_c = abl_wd_pkg::OUT_MIN[OUT_W-1:0];
		else dis_c = dd[OUT_W-1:0];
		if (dp > abl_wd_pkg::OUT_MAX) prod_c = abl_wd_pkg::OUT_MAX[OUT_W-1:0];
		else if (dp < abl_wd_pkg::OUT_MIN) prod_c = abl_wd_pkg::OUT_MIN[OUT_W-1:0];
		else prod_c = dp[OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= m2_valid;
	end

	always_ff @(posedge clk) begin
		res_s5.denom_zero  <= m2_side[0];
		res_s5.dissipation <= m2_side[0] ? '0 : $signed(dis_c);
		res_s5.production  <= m2_side[0] ? '0 : $signed(prod_c);
	end

	assign done   = v_s5;
	assign result = res_s5;

	a_zero_forces_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.denom_zero |-> result.dissipation == '0 && result.production == '0)
		else $error("zero denominator item with nonzero result");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ##92 done)
		else $error("item did not reach the output on time");

	a_tail_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s4, 7))
		else $error("result without a matching item at the divider output");

	a_dudy_capped: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> dudy_s4 <= abl_wd_pkg::CAP)
		else $error("dU/dy above cap");
endmodule

// ===== tb/sv/tb_abl_wall_dissipation_production.sv =====
// Self-checking testbench for the rough-wall dissipation/production pipeline.
module tb_abl_wall_dissipation_production;
	timeunit 1ns;
	timeprecision 1ps;
	import abl_wd_pkg::*;

	localparam logic [63:0] SAT_CAP = 64'd1 << 41;
	localparam longint DIS_MAX = 64'sd549755813887;
	localparam longint DIS_MIN = -64'sd549755813888;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'd7;

	typedef enum int {V_RAND, V_SMALL, V_ZERO, V_MAX} span_e;

	class wall_scoreboard;
		logic [CFG_W-1:0] cmu;
		logic [CFG_W-1:0] kappa;
		result_t          faces_due[$];
		int               errors;
		int               checked;
		int               zero_den;

		function new();
			cmu = CMU_RESET;
			kappa = KAPPA_RESET;
			errors = 0;
			checked = 0;
			zero_den = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_CMU)
				cmu = data[CFG_W-1:0];
			else if (idx == REG_KAPPA)
				kappa = data[CFG_W-1:0];
		endfunction

		function logic [63:0] root_floor(logic [63:0] v);
			logic [63:0] res;
			logic [63:0] b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// (a*b)>>16, held at the cap; a 64-bit overflow also gives the cap
		function logic [63:0] scaled_mul(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			logic [63:0]  r;
			p = {64'd0, a} * {64'd0, b};
			if (p[127:64] != 0)
				return SAT_CAP;
			r = p[79:16];
			return (r > SAT_CAP) ? SAT_CAP : r;
		endfunction

		function logic signed [OUT_W-1:0] clamp40(logic [63:0] pos, logic [63:0] neg);
			longint d;
			d = longint'(pos) - longint'(neg);
			if (d > DIS_MAX)
				d = DIS_MAX;
			if (d < DIS_MIN)
				d = DIS_MIN;
			return d[OUT_W-1:0];
		endfunction

		function result_t wall_terms(item_t it);
			result_t     r;
			logic [63:0] c, kap, den, sk, ut, dudy, ck, ng, visc;
			c = cmu;
			kap = kappa;
			den = kap * ({32'd0, it.wall_distance} + {32'd0, it.roughness_length});
			r = '0;
			if (den == 0) begin
				r.denom_zero = 1'b1;
				return r;
			end
			sk = root_floor({16'd0, it.cell_tke, 16'd0});
			ut = (c * sk) >> 16;
			dudy = (ut << 32) / den;
			if (dudy > SAT_CAP)
				dudy = SAT_CAP;
			ck = (c * ((c * {32'd0, it.cell_tke}) >> 16)) >> 16;
			ng = ({32'd0, it.eddy_visc} * {32'd0, it.shear_grad}) >> 16;
			visc = scaled_mul(scaled_mul({32'd0, it.laminar_visc}, dudy), dudy);
			r.dissipation = clamp40(scaled_mul(ck, dudy), visc);
			r.production = clamp40(scaled_mul(ng, dudy), visc);
			return r;
		endfunction

		function void note_face(item_t it);
			result_t r;
			r = wall_terms(it);
			if (r.denom_zero)
				zero_den++;
			faces_due.push_back(r);
		endfunction

		function void check_face(result_t act);
			result_t exp_r;
			if (faces_due.size() == 0) begin
				$display("%0t: unexpected result %h", $time, act);
				errors++;
				return;
			end
			exp_r = faces_due.pop_front();
			checked++;
			if (act.dissipation !== exp_r.dissipation) begin
				$display("%0t: dissipation expected %0d actual %0d", $time,
					exp_r.dissipation, act.dissipation);
				errors++;
			end
			if (act.production !== exp_r.production) begin
				$display("%0t: production expected %0d actual %0d", $time,
					exp_r.production, act.production);
				errors++;
			end
			if (act.denom_zero !== exp_r.denom_zero) begin
				$display("%0t: denom_zero expected %0b actual %0b", $time,
					exp_r.denom_zero, act.denom_zero);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	item_t                 item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  done;
	result_t               result;

	wall_scoreboard sb;
	int             idle_pct;

	abl_wall_dissipation_production uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("[abl_wall_dissipation_production] ERROR");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check_face(result);

	function automatic logic [31:0] pick_val(span_e s);
		case (s)
			V_SMALL: return $urandom >> $urandom_range(31, 8);
			V_ZERO:  return 32'd0;
			V_MAX:   return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_field();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return pick_val(V_RAND);
		else if (r < 85)
			return pick_val(V_SMALL);
		else if (r < 93)
			return pick_val(V_ZERO);
		return pick_val(V_MAX);
	endfunction

	function automatic item_t rand_face();
		item_t it;
		it.cell_tke = rand_field();
		it.wall_distance = rand_field();
		it.roughness_length = rand_field();
		it.laminar_visc = rand_field();
		it.eddy_visc = rand_field();
		it.shear_grad = rand_field();
		if ($urandom_range(99) < 5) begin
			it.wall_distance = 0;
			it.roughness_length = 0;
		end
		return it;
	endfunction

	task automatic send_face(item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		sb.note_face(it);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.faces_due.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic directed_faces();
		item_t it;
		it = '0;
		send_face(it);
		it = '1;
		send_face(it);
		// zero wall distance and roughness: flag case
		it.wall_distance = 0;
		it.roughness_length = 0;
		send_face(it);
		it = '1;
		it.wall_distance = 32'd1;
		it.roughness_length = 32'd0;
		send_face(it);
		it.wall_distance = 32'd0;
		it.roughness_length = 32'd1;
		send_face(it);
		it = '0;
		it.wall_distance = 32'h0001_0000;
		send_face(it);
		it.cell_tke = 32'hFFFF_FFFF;
		send_face(it);
		it.laminar_visc = 32'hFFFF_FFFF;
		send_face(it);
		it.laminar_visc = 0;
		it.eddy_visc = 32'hFFFF_FFFF;
		it.shear_grad = 32'hFFFF_FFFF;
		send_face(it);
		it.wall_distance = 32'd1;
		send_face(it);
		it = '0;
		it.cell_tke = 32'h0001_0000;
		it.wall_distance = 32'h0000_8000;
		it.roughness_length = 32'h0000_0100;
		it.laminar_visc = 32'h0000_0010;
		it.eddy_visc = 32'h0000_4000;
		it.shear_grad = 32'h0002_0000;
		send_face(it);
		for (int b = 0; b < 32; b += 4) begin
			it = '0;
			it.cell_tke = 32'd1 << b;
			it.wall_distance = 32'd1 << (31 - b);
			it.roughness_length = 32'd1 << b;
			it.laminar_visc = 32'd1 << b;
			it.eddy_visc = 32'd1 << (31 - b);
			it.shear_grad = 32'd1 << b;
			send_face(it);
		end
	endtask

	initial begin
		int pcts[3];
		pcts = '{11, 87, 0};
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: begin
					write_reg(REG_CMU, 32'h3FFFF);
					write_reg(REG_KAPPA, 32'd1);
				end
				2: begin
					write_reg(REG_CMU, 32'd0);
					write_reg(REG_KAPPA, 32'h3FFFF);
				end
				3: begin
					// high bits dropped, kappa becomes zero; bad index ignored
					write_reg(REG_CMU, 32'hFFFC_0000 | 32'd40000);
					write_reg(REG_KAPPA, 32'hFFFC_0000);
					write_reg(REG_NONE, 32'd5);
				end
				4: begin
					write_reg(REG_CMU, $urandom_range(262143));
					write_reg(REG_KAPPA, $urandom_range(262143, 1));
				end
				5: begin
					write_reg(REG_CMU, CMU_RESET);
					write_reg(REG_KAPPA, KAPPA_RESET);
				end
				default: ;
			endcase
			idle_pct = pcts[ph % 3];
			if (ph == 0)
				directed_faces();
			for (int n = 0; n < 165; n++)
				send_face(rand_face());
			drain();
		end
		$display("Checked %0d wall faces over 6 register settings (%0d zero denominators).",
			sb.checked, sb.zero_den);
		if (sb.errors == 0 && sb.faces_due.size() == 0)
			$display("[abl_wall_dissipation_production] OK");
		else
			$display("[abl_wall_dissipation_production] ERROR");
		$finish;
	end
endmodule
